// File: sv/tscu_pkg.sv
// Package for the thin-scatter covariance update block.
// Holds fixed-point constants, register reset values and register index codes.
// No dependencies.
package tscu_pkg;

    // Fixed-point constants.
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [31:0] C038_Q32 = 32'd163208757;
    localparam logic [26:0] ONE_Q24  = 27'd16777216;
    localparam logic [63:0] ONE_Q48  = 64'd281474976710656;
    localparam logic [31:0] P_MIN    = 32'd256;

    // Register reset values.
    localparam logic [31:0] FUDGE_RST   = 32'd16777216;
    localparam logic [23:0] MOLIERE_RST = 24'd891290;
    localparam logic [31:0] THRESH_RST  = 32'd0;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_FUDGE   = 2'd0,
        REG_MOLIERE = 2'd1,
        REG_THRESH  = 2'd2
    } t_reg_idx;

endpackage

// File: sv/thin_scatter_covariance_update.sv
// Thin-scatter covariance update: Highland multiple-scattering noise added
// to the slope covariance entries of a track state. Uses tscu_pkg.
//
//  Channel   Direction  Handshake               Payload
//  s stream  in         i_s_tvalid/o_s_tready   i_s_tdata  (304 bits)
//  m stream  out        o_m_tvalid/i_m_tready   o_m_tdata  (144 bits)
//  config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// One transaction is accepted per cycle unless the pipeline holds (see below). The
// pipeline holds the thickness divider and square root (32 steps), the
// log squaring chain (two stages per fraction bit) and the 60-step noise divider.
// Reset clears the stage valid bits and loads the register defaults.
// When the output register is full and not taken, the whole pipeline holds.
module thin_scatter_covariance_update #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // slope_x, slope_y, momentum, wall_thickness, radiation_length, cov_xx, cov_yx, cov_yy
    input  logic [303:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // new_cov_xx, new_cov_yx, new_cov_yy
    output logic [143:0] o_m_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import tscu_pkg::*;

    localparam int LTB    = LOG_TABLE_BITS;
    localparam int S_MUL  = 1;
    localparam int S_NORM = 2;
    localparam int S_DV0  = 3;
    localparam int S_GATE = S_DV0 + 32;
    localparam int S_RT   = S_GATE + 1;
    localparam int S_NZ0  = S_RT + 1;
    localparam int S_LG0  = S_NZ0 + 6;
    localparam int S_L2   = S_LG0 + 2 * LTB;
    localparam int S_LNM  = S_L2 + 1;
    localparam int S_TERM = S_L2 + 2;
    localparam int S_FAC  = S_L2 + 3;
    localparam int S_MF   = S_L2 + 4;
    localparam int S_MF2  = S_L2 + 5;
    localparam int S_SC   = S_L2 + 6;
    localparam int S_A    = S_L2 + 9;
    localparam int S_B    = S_L2 + 12;
    localparam int S_NDI  = S_L2 + 15;
    localparam int S_ND0  = S_L2 + 16;
    localparam int S_MXX  = S_ND0 + 60;
    localparam int S_MYX  = S_MXX + 3;
    localparam int S_MYY  = S_MYX + 3;
    localparam int S_OUT  = S_MYY + 3;
    localparam int NSTG   = S_OUT + 1;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic [31:0]       ax;
        logic [31:0]       ay;
        logic              sgn;
        logic [31:0]       p;
        logic [31:0]       wall;
        logic [31:0]       rad;
        logic [47:0]       cxx;
        logic [47:0]       cyx;
        logic [47:0]       cyy;
        logic [63:0]       tx2;
        logic [63:0]       ty2;
        logic [63:0]       axy;
        logic [63:0]       p2;
        logic [63:0]       norm2;
        logic [63:0]       sqn;
        logic [33:0]       sqr;
        logic [31:0]       sqs;
        logic [31:0]       tr;
        logic [31:0]       tn;
        logic [31:0]       tq;
        logic              tsat;
        logic [31:0]       t;
        logic              gate;
        logic [63:0]       rt;
        logic [63:0]       nx;
        logic [5:0]        m;
        logic [31:0]       y;
        logic [63:0]       ysq;
        logic [LTB-1:0]    fr;
        logic              lneg;
        logic [LTB+6:0]    lmag;
        logic [29:0]       lnm;
        logic [25:0]       term;
        logic [26:0]       fac;
        logic [26:0]       mf;
        logic [53:0]       mf2;
        logic [3:0][63:0]  pp;
        logic [127:0]      acc;
        logic [63:0]       scat;
        logic [63:0]       a;
        logic [63:0]       b;
        logic [63:0]       dr;
        logic [59:0]       dn;
        logic [59:0]       nq;
        logic [63:0]       qxx;
        logic [63:0]       qyx;
        logic [63:0]       qyy;
    } t_pl;

    logic [31:0] r_fudge;
    logic [23:0] r_moliere;
    logic [31:0] r_thresh;
    t_pl         r_pl [NSTG];
    t_pl         n_pl [NSTG];
    logic        r_vld [NSTG];
    logic        w_en;

    // Four 32x32 partial products of a 64x64 multiply.
    function automatic logic [3:0][63:0] pp64(input logic [63:0] a, input logic [63:0] b);
        logic [3:0][63:0] r;
        r[0] = 64'(a[31:0]) * 64'(b[31:0]);
        r[1] = 64'(a[31:0]) * 64'(b[63:32]);
        r[2] = 64'(a[63:32]) * 64'(b[31:0]);
        r[3] = 64'(a[63:32]) * 64'(b[63:32]);
        return r;
    endfunction

    function automatic logic [127:0] pp_sum(input logic [3:0][63:0] p);
        return {64'd0, p[0]} + {32'd0, p[1], 32'd0} + {32'd0, p[2], 32'd0} + {p[3], 64'd0};
    endfunction

    // Product shifted right, saturated to 64 bits.
    function automatic logic [63:0] sat_shr(input logic [127:0] x, input int sh);
        logic [127:0] s;
        s = x >> sh;
        return (s[127:64] != 64'd0) ? '1 : s[63:0];
    endfunction

    // Covariance plus or minus the noise term, saturated to 48 bits signed.
    function automatic logic [47:0] add_sat48(input logic [47:0] c, input logic [63:0] q,
                                              input logic neg);
        logic [49:0]        qc;
        logic signed [51:0] cs;
        logic signed [51:0] qs;
        logic signed [51:0] s;
        qc = (q > 64'(50'd1 << 49)) ? (50'd1 << 49) : q[49:0];
        cs = {{4{c[47]}}, c};
        qs = {2'b00, qc};
        s  = neg ? (cs - qs) : (cs + qs);
        if (s > 52'sh7FFFFFFFFFFF) begin
            return 48'h7FFFFFFFFFFF;
        end else if (s < -52'sh800000000000) begin
            return 48'h800000000000;
        end else begin
            return s[47:0];
        end
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fudge   <= FUDGE_RST;
            r_moliere <= MOLIERE_RST;
            r_thresh  <= THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FUDGE:   r_fudge   <= i_cfg_data;
                REG_MOLIERE: r_moliere <= i_cfg_data[23:0];
                REG_THRESH:  r_thresh  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // The pipeline advances unless the output register is full and stalled.
    assign w_en       = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {r_pl[NSTG-1].cyy, r_pl[NSTG-1].cyx, r_pl[NSTG-1].cxx};

    // Input stage: unpack, take slope magnitudes, clamp momentum.
    always_comb begin
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] pm;
        sx = i_s_tdata[31:0];
        sy = i_s_tdata[63:32];
        pm = i_s_tdata[95:64];
        n_pl[0]      = '0;
        n_pl[0].ax   = sx[31] ? (32'd0 - sx) : sx;
        n_pl[0].ay   = sy[31] ? (32'd0 - sy) : sy;
        n_pl[0].sgn  = sx[31] ^ sy[31];
        n_pl[0].p    = (pm < P_MIN) ? P_MIN : pm;
        n_pl[0].wall = i_s_tdata[127:96];
        n_pl[0].rad  = i_s_tdata[159:128];
        n_pl[0].cxx  = i_s_tdata[207:160];
        n_pl[0].cyx  = i_s_tdata[255:208];
        n_pl[0].cyy  = i_s_tdata[303:256];
    end

    for (genvar k = 1; k < NSTG; k++) begin : g_stg
        if (k == S_MUL) begin : g_mul
            // Slope squares, cross term, momentum square; thickness divider setup.
            always_comb begin
                n_pl[k]      = r_pl[k-1];
                n_pl[k].tx2  = 64'(r_pl[k-1].ax) * 64'(r_pl[k-1].ax);
                n_pl[k].ty2  = 64'(r_pl[k-1].ay) * 64'(r_pl[k-1].ay);
                n_pl[k].axy  = 64'(r_pl[k-1].ax) * 64'(r_pl[k-1].ay);
                n_pl[k].p2   = 64'(r_pl[k-1].p) * 64'(r_pl[k-1].p);
                n_pl[k].tsat = (32'(r_pl[k-1].wall[31:16]) >= r_pl[k-1].rad);
                n_pl[k].tr   = 32'(r_pl[k-1].wall[31:16]);
                n_pl[k].tn   = {r_pl[k-1].wall[15:0], 16'd0};
                n_pl[k].tq   = '0;
            end
        end else if (k == S_NORM) begin : g_norm
            // norm2 = 1 + tx^2 + ty^2 and square root setup.
            always_comb begin
                n_pl[k]       = r_pl[k-1];
                n_pl[k].norm2 = ONE_Q48 + r_pl[k-1].tx2 + r_pl[k-1].ty2;
                n_pl[k].sqn   = n_pl[k].norm2;
                n_pl[k].sqr   = '0;
                n_pl[k].sqs   = '0;
            end
        end else if (k >= S_DV0 && k < S_GATE) begin : g_dv
            // One quotient bit of the thickness ratio and one root bit per stage.
            always_comb begin
                logic [32:0] tt;
                logic [35:0] rr;
                logic [35:0] ts;
                n_pl[k] = r_pl[k-1];
                tt = {r_pl[k-1].tr, r_pl[k-1].tn[31]};
                n_pl[k].tn = {r_pl[k-1].tn[30:0], 1'b0};
                if (tt >= 33'(r_pl[k-1].rad)) begin
                    n_pl[k].tr = 32'(tt - 33'(r_pl[k-1].rad));
                    n_pl[k].tq = {r_pl[k-1].tq[30:0], 1'b1};
                end else begin
                    n_pl[k].tr = tt[31:0];
                    n_pl[k].tq = {r_pl[k-1].tq[30:0], 1'b0};
                end
                rr = {r_pl[k-1].sqr, r_pl[k-1].sqn[63:62]};
                ts = {2'b00, r_pl[k-1].sqs, 2'b01};
                n_pl[k].sqn = {r_pl[k-1].sqn[61:0], 2'b00};
                if (rr >= ts) begin
                    n_pl[k].sqr = 34'(rr - ts);
                    n_pl[k].sqs = {r_pl[k-1].sqs[30:0], 1'b1};
                end else begin
                    n_pl[k].sqr = rr[33:0];
                    n_pl[k].sqs = {r_pl[k-1].sqs[30:0], 1'b0};
                end
            end
        end else if (k == S_GATE) begin : g_gate
            // Saturated thickness ratio and the threshold test.
            always_comb begin
                n_pl[k]      = r_pl[k-1];
                n_pl[k].t    = r_pl[k-1].tsat ? '1 : r_pl[k-1].tq;
                n_pl[k].gate = (n_pl[k].t > r_thresh);
            end
        end else if (k == S_RT) begin : g_rt
            // radThick = sqrt(norm2) * t.
            always_comb begin
                n_pl[k]    = r_pl[k-1];
                n_pl[k].rt = 64'(r_pl[k-1].sqs) * 64'(r_pl[k-1].t);
                n_pl[k].nx = n_pl[k].rt;
                n_pl[k].m  = 6'd63;
            end
        end else if (k >= S_NZ0 && k < S_LG0) begin : g_nz
            // Normalize radThick: shift by 32, 16, ... 1 when the top bits are clear.
            localparam int K = 32 >> (k - S_NZ0);
            always_comb begin
                n_pl[k] = r_pl[k-1];
                if (r_pl[k-1].nx[63 -: K] == '0) begin
                    n_pl[k].nx = r_pl[k-1].nx << K;
                    n_pl[k].m  = r_pl[k-1].m - 6'(K);
                end
                n_pl[k].y  = n_pl[k].nx[63:32];
                n_pl[k].fr = '0;
            end
        end else if (k >= S_LG0 && k < S_L2 && ((k - S_LG0) % 2 == 0)) begin : g_lsq
            // Square the mantissa.
            always_comb begin
                n_pl[k]     = r_pl[k-1];
                n_pl[k].ysq = 64'(r_pl[k-1].y) * 64'(r_pl[k-1].y);
            end
        end else if (k >= S_LG0 && k < S_L2) begin : g_lbit
            // Take one fraction bit of log2 and renormalize.
            always_comb begin
                logic [32:0] v;
                n_pl[k] = r_pl[k-1];
                v = r_pl[k-1].ysq[63:31];
                n_pl[k].fr = {r_pl[k-1].fr[LTB-2:0], v[32]};
                n_pl[k].y  = v[32] ? v[32:1] : v[31:0];
            end
        end else if (k == S_L2) begin : g_l2
            // log2 = (msb - 40) + fraction, as sign and magnitude.
            always_comb begin
                logic signed [7:0]     me;
                logic signed [LTB+7:0] l2;
                n_pl[k] = r_pl[k-1];
                me = signed'({2'b00, r_pl[k-1].m}) - 8'sd40;
                l2 = signed'({me, r_pl[k-1].fr});
                n_pl[k].lneg = me[7];
                n_pl[k].lmag = me[7] ? (LTB+7)'(-l2) : (LTB+7)'(l2);
            end
        end else if (k == S_LNM) begin : g_lnm
            // Natural log magnitude, Q.24.
            always_comb begin
                logic [LTB+38:0] lp;
                n_pl[k] = r_pl[k-1];
                lp = (LTB+39)'(r_pl[k-1].lmag) * (LTB+39)'(LN2_Q32);
                n_pl[k].lnm = 30'(lp >> (LTB + 8));
            end
        end else if (k == S_TERM) begin : g_term
            // 0.038 * ln.
            always_comb begin
                logic [61:0] tp;
                n_pl[k] = r_pl[k-1];
                tp = 62'(r_pl[k-1].lnm) * 62'(C038_Q32);
                n_pl[k].term = tp[57:32];
            end
        end else if (k == S_FAC) begin : g_fac
            // 1 + 0.038 * ln, clamped at zero.
            always_comb begin
                n_pl[k] = r_pl[k-1];
                if (r_pl[k-1].lneg) begin
                    n_pl[k].fac = (27'(r_pl[k-1].term) >= ONE_Q24) ? '0
                                  : ONE_Q24 - 27'(r_pl[k-1].term);
                end else begin
                    n_pl[k].fac = ONE_Q24 + 27'(r_pl[k-1].term);
                end
            end
        end else if (k == S_MF) begin : g_mf
            // Highland constant times the log factor, Q.16.
            always_comb begin
                logic [50:0] mp;
                n_pl[k] = r_pl[k-1];
                mp = 51'(r_moliere) * 51'(r_pl[k-1].fac);
                n_pl[k].mf = mp[50:24];
            end
        end else if (k == S_MF2) begin : g_mf2
            always_comb begin
                n_pl[k]     = r_pl[k-1];
                n_pl[k].mf2 = 54'(r_pl[k-1].mf) * 54'(r_pl[k-1].mf);
            end
        end else if (k == S_SC) begin : g_scp
            always_comb begin
                n_pl[k]    = r_pl[k-1];
                n_pl[k].pp = pp64(r_pl[k-1].rt, 64'(r_pl[k-1].mf2));
            end
        end else if (k == S_A) begin : g_ap
            always_comb begin
                n_pl[k]    = r_pl[k-1];
                n_pl[k].pp = pp64(r_pl[k-1].norm2, 64'(r_fudge));
            end
        end else if (k == S_B) begin : g_bp
            always_comb begin
                n_pl[k]    = r_pl[k-1];
                n_pl[k].pp = pp64(r_pl[k-1].a, r_pl[k-1].scat);
            end
        end else if (k == S_MXX) begin : g_xxp
            always_comb begin
                n_pl[k]    = r_pl[k-1];
                n_pl[k].pp = pp64(64'(r_pl[k-1].nq), ONE_Q48 + r_pl[k-1].tx2);
            end
        end else if (k == S_MYX) begin : g_yxp
            always_comb begin
                n_pl[k]    = r_pl[k-1];
                n_pl[k].pp = pp64(64'(r_pl[k-1].nq), r_pl[k-1].axy);
            end
        end else if (k == S_MYY) begin : g_yyp
            always_comb begin
                n_pl[k]    = r_pl[k-1];
                n_pl[k].pp = pp64(64'(r_pl[k-1].nq), ONE_Q48 + r_pl[k-1].ty2);
            end
        end else if (k == S_SC + 1 || k == S_A + 1 || k == S_B + 1 || k == S_MXX + 1
                     || k == S_MYX + 1 || k == S_MYY + 1) begin : g_sum
            // Add up the partial products.
            always_comb begin
                n_pl[k]     = r_pl[k-1];
                n_pl[k].acc = pp_sum(r_pl[k-1].pp);
            end
        end else if (k == S_SC + 2) begin : g_scs
            // scat, zero when the thickness ratio is not above the threshold.
            always_comb begin
                n_pl[k]      = r_pl[k-1];
                n_pl[k].scat = r_pl[k-1].gate ? sat_shr(r_pl[k-1].acc, 32) : '0;
            end
        end else if (k == S_A + 2) begin : g_as
            always_comb begin
                n_pl[k]   = r_pl[k-1];
                n_pl[k].a = sat_shr(r_pl[k-1].acc, 24);
            end
        end else if (k == S_B + 2) begin : g_bs
            always_comb begin
                n_pl[k]   = r_pl[k-1];
                n_pl[k].b = sat_shr(r_pl[k-1].acc, 40);
            end
        end else if (k == S_NDI) begin : g_ndi
            // Noise divider setup: dividend is b * 2^12, divisor p^2.
            always_comb begin
                n_pl[k]    = r_pl[k-1];
                n_pl[k].dr = 64'(r_pl[k-1].b[63:48]);
                n_pl[k].dn = {r_pl[k-1].b[47:0], 12'd0};
                n_pl[k].nq = '0;
            end
        end else if (k >= S_ND0 && k < S_MXX) begin : g_nd
            // One quotient bit of the noise per stage.
            always_comb begin
                logic [64:0] rr;
                n_pl[k] = r_pl[k-1];
                rr = {r_pl[k-1].dr, r_pl[k-1].dn[59]};
                n_pl[k].dn = {r_pl[k-1].dn[58:0], 1'b0};
                if (rr >= 65'(r_pl[k-1].p2)) begin
                    n_pl[k].dr = 64'(rr - 65'(r_pl[k-1].p2));
                    n_pl[k].nq = {r_pl[k-1].nq[58:0], 1'b1};
                end else begin
                    n_pl[k].dr = rr[63:0];
                    n_pl[k].nq = {r_pl[k-1].nq[58:0], 1'b0};
                end
            end
        end else if (k == S_MXX + 2) begin : g_xxs
            always_comb begin
                n_pl[k]     = r_pl[k-1];
                n_pl[k].qxx = sat_shr(r_pl[k-1].acc, 48);
            end
        end else if (k == S_MYX + 2) begin : g_yxs
            always_comb begin
                n_pl[k]     = r_pl[k-1];
                n_pl[k].qyx = sat_shr(r_pl[k-1].acc, 48);
            end
        end else if (k == S_MYY + 2) begin : g_yys
            always_comb begin
                n_pl[k]     = r_pl[k-1];
                n_pl[k].qyy = sat_shr(r_pl[k-1].acc, 48);
            end
        end else begin : g_out
            // Saturating covariance update into the output register.
            always_comb begin
                n_pl[k]     = r_pl[k-1];
                n_pl[k].cxx = add_sat48(r_pl[k-1].cxx, r_pl[k-1].qxx, 1'b0);
                n_pl[k].cyx = add_sat48(r_pl[k-1].cyx, r_pl[k-1].qyx, r_pl[k-1].sgn);
                n_pl[k].cyy = add_sat48(r_pl[k-1].cyy, r_pl[k-1].qyy, 1'b0);
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_s_tvalid;
            for (int i = 1; i < NSTG; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NSTG; i++) begin
                r_pl[i] <= n_pl[i];
            end
        end
    end

endmodule

// File: sim/tb_thin_scatter_covariance_update.sv
// Self-checking testbench for thin_scatter_covariance_update.
// A scoreboard class predicts each updated covariance triple bit for bit from the
// accepted input transaction; depends on tscu_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_thin_scatter_covariance_update;
    import tscu_pkg::*;

    localparam int LOG_BITS = 8;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT = 200;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Scoreboard: holds a copy of the registers and the queue of predicted triples.
    class cov_scoreboard;
        logic [31:0] fudge_sq;
        logic [23:0] moliere;
        logic [31:0] threshold;
        logic [143:0] pending_covs[$];
        int mismatches;

        function new();
            fudge_sq = FUDGE_RST;
            moliere = MOLIERE_RST;
            threshold = THRESH_RST;
            mismatches = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_FUDGE:   fudge_sq = val;
                REG_MOLIERE: moliere = val[23:0];
                REG_THRESH:  threshold = val;
                default:     ;
            endcase
        endfunction

        // (a*b) >> sh, saturated to 64 bits.
        function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
            logic [127:0] prod;
            prod = {64'd0, a} * {64'd0, b};
            if ((prod >> (64 + sh)) != 0) return ALL_ONES;
            return 64'(prod >> sh);
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] n);
            logic [63:0] root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= root + bitv) begin
                    n = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // Natural log of a Q24.40 value as a Q.24 magnitude, with its sign.
        function logic [63:0] log_q24(logic [63:0] r, output bit neg);
            int msb;
            logic [63:0] y, frac, magn;
            longint l2;
            msb = 63;
            while (msb > 0 && !r[msb]) msb--;
            y = (msb >= 31) ? (r >> (msb - 31)) : (r << (31 - msb));
            frac = 0;
            for (int i = 0; i < LOG_BITS; i++) begin
                y = (y * y) >> 31;
                frac = frac << 1;
                if (y >= (64'd1 << 32)) begin
                    frac[0] = 1'b1;
                    y = y >> 1;
                end
            end
            l2 = longint'(msb - 40) * (longint'(1) << LOG_BITS) + longint'(frac);
            neg = l2 < 0;
            magn = (l2 < 0) ? -l2 : l2;
            return (magn * {32'd0, LN2_Q32}) >> (LOG_BITS + 8);
        endfunction

        function logic [47:0] add_sat(logic [47:0] cov, logic [63:0] q, bit neg);
            longint c, s;
            c = longint'(signed'(cov));
            if (q > (64'd1 << 49)) q = 64'd1 << 49;
            s = neg ? c - longint'(q) : c + longint'(q);
            if (s > (longint'(1) << 47) - 1) s = (longint'(1) << 47) - 1;
            if (s < -(longint'(1) << 47)) s = -(longint'(1) << 47);
            return s[47:0];
        endfunction

        function logic [143:0] predict_cov(logic [303:0] d);
            logic [63:0] ax, ay, mom, wall, rad, tx2, ty2, norm2, thick, scat;
            logic [63:0] rt, lnm, term, factor, mf, a, b, p2, noise;
            bit nx, ny, nl;
            nx = d[31];
            ny = d[63];
            ax = nx ? 64'h1_0000_0000 - {32'd0, d[31:0]} : {32'd0, d[31:0]};
            ay = ny ? 64'h1_0000_0000 - {32'd0, d[63:32]} : {32'd0, d[63:32]};
            mom = {32'd0, d[95:64]};
            wall = {32'd0, d[127:96]};
            rad = {32'd0, d[159:128]};
            tx2 = ax * ax;
            ty2 = ay * ay;
            norm2 = ONE_Q48 + tx2 + ty2;
            // A zero radiation length counts as an infinitely thick wall.
            if (rad == 0) begin
                thick = 64'hFFFF_FFFF;
            end else begin
                thick = (wall << 16) / rad;
                if (thick > 64'hFFFF_FFFF) thick = 64'hFFFF_FFFF;
            end
            scat = 0;
            if (thick > {32'd0, threshold}) begin
                rt = int_sqrt(norm2) * thick;
                lnm = log_q24(rt, nl);
                term = (lnm * {32'd0, C038_Q32}) >> 32;
                if (nl) factor = (term >= ONE_Q24) ? 0 : ONE_Q24 - term;
                else factor = ONE_Q24 + term;
                mf = ({40'd0, moliere} * factor) >> 24;
                scat = mul_shift(rt, mf * mf, 32);
            end
            if (mom < P_MIN) mom = P_MIN;
            p2 = mom * mom;
            a = mul_shift(norm2, {32'd0, fudge_sq}, 24);
            b = mul_shift(a, scat, 40);
            if ((b >> 52) >= p2) noise = ALL_ONES;
            else noise = 64'(({64'd0, b} << 12) / p2);
            return {add_sat(d[303:256], mul_shift(noise, ONE_Q48 + ty2, 48), 0),
                    add_sat(d[255:208], mul_shift(noise, ax * ay, 48), nx != ny),
                    add_sat(d[207:160], mul_shift(noise, ONE_Q48 + tx2, 48), 0)};
        endfunction

        function void note_input(logic [303:0] d);
            pending_covs.push_back(predict_cov(d));
        endfunction

        function void check_result(logic [143:0] got);
            logic [143:0] want;
            if (pending_covs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction %h", got);
                return;
            end
            want = pending_covs.pop_front();
            for (int f = 0; f < 3; f++) begin
                if (got[f*48 +: 48] !== want[f*48 +: 48]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Covariance field %0d mismatch: expected %h, got %h",
                                 f, want[f*48 +: 48], got[f*48 +: 48]);
                end
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [303:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_idx = REG_FUDGE;
    logic [31:0]  cfg_data = '0;

    cov_scoreboard sb = new();
    int send_idle = 0;
    int recv_stall = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cnt = 0;
    int cycles = 0;

    thin_scatter_covariance_update #(.LOG_TABLE_BITS(LOG_BITS)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Monitors on both streams feed the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) sb.note_input(s_tdata);
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= 600;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [303:0] make_item(logic [31:0] sx, logic [31:0] sy,
                                               logic [31:0] mom, logic [31:0] wall,
                                               logic [31:0] rad, logic [47:0] cxx,
                                               logic [47:0] cyx, logic [47:0] cyy);
        return {cyy, cyx, cxx, rad, wall, mom, sy, sx};
    endfunction

    function automatic logic [31:0] rand_slope();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(33554432)) - 16777216);
            2: return 32'(signed'($urandom_range(536870912)) - 268435456);
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [47:0] rand_cov();
        case ($urandom_range(2))
            0: return 48'({$urandom, $urandom});
            1: return 48'(signed'($urandom_range(2000000)) - 1000000);
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, $urandom};
        endcase
    endfunction

    function automatic logic [303:0] rand_item();
        logic [31:0] mom, wall, rad;
        case ($urandom_range(2))
            0: mom = $urandom;
            1: mom = $urandom_range(511);
            default: mom = $urandom_range(400000) << 8;
        endcase
        wall = $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 22);
        rad = $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 26, 1);
        return make_item(rand_slope(), rand_slope(), mom, wall, rad,
                         rand_cov(), rand_cov(), rand_cov());
    endfunction

    task automatic send_item(logic [303:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Every burst is followed by a drain, which drops tvalid.
    task automatic send_random(int n);
        for (int i = 0; i < n; i++) send_item(rand_item());
    endtask

    // Wait until every predicted triple has come back, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_covs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // The caller drops the write enable after the last register write.
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic setup(logic [31:0] fudge, logic [31:0] mol, logic [31:0] thr);
        drain();
        write_reg(REG_FUDGE, fudge);
        write_reg(REG_MOLIERE, mol);
        write_reg(REG_THRESH, thr);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed transactions, first with the reset register values, then with two other settings.
        send_item(make_item(0, 0, 32'd256000, 32'd65536, 32'd65536, 0, 0, 0));
        send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1,
                            48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF));
        send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'd255, 32'd1000, 0,
                            48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000));
        send_item(make_item(32'h0100_0000, 32'hFF00_0000, 32'd256, 32'd65536, 32'd1,
                            0, 48'h8000_0000_0001, 0));
        send_item(make_item(32'h0080_0000, 32'h0040_0000, 32'hFFFF_FFFF, 0, 32'd1000,
                            48'h1234_5678_9ABC, 48'hFEDC_BA98_7654, 48'h0F0F_0F0F_0F0F));
        send_item(make_item(0, 0, 32'd25600, 32'd1, 32'hFFFF_FFFF, 0, 0, 0));
        send_item(make_item(0, 0, 32'd256, 32'd1, 32'd65536, 0, 0, 0));
        send_item(make_item(32'hFFFF_FFFF, 32'd1, 32'd1, 32'd3276800, 32'd576716800,
                            48'h7FFF_FFFF_FFF0, 48'h0, 48'h8000_0000_0000));
        send_item(make_item(32'h1000_0000, 32'hF000_0000, 32'd2560, 32'hFFFF_FFFF, 0,
                            48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h0));
        send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'd256, 32'hFFFF_FFFF, 1,
                            0, 0, 0));
        setup(32'hFFFF_FFFF, 32'hFF_FFFF, 0);
        send_item(make_item(32'h0200_0000, 32'hFE00_0000, 32'd256000, 32'd65536,
                            32'd65536, 0, 0, 0));
        send_item(make_item(0, 0, 32'd256, 32'd1, 32'd65536, 0, 0, 0));
        setup(0, 0, 32'hFFFF_FFFF);
        send_item(make_item(32'h0200_0000, 32'h0100_0000, 32'd256, 0, 0,
                            48'h1, 48'h2, 48'h3));
        send_item(make_item(32'h0200_0000, 32'h0100_0000, 32'd256, 32'd100, 32'd1,
                            48'h1, 48'h2, 48'h3));

        // Random phases across register settings and idle mixes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: setup(FUDGE_RST, MOLIERE_RST, THRESH_RST);
                1: setup(32'hFFFF_FFFF, 32'hFF_FFFF, 0);
                2: setup(0, MOLIERE_RST, 0);
                3: setup(FUDGE_RST, 0, 32'd6553);
                4: setup(32'hFFFF_FFFF, MOLIERE_RST, 32'hFFFF_FFFF);
                5: setup($urandom, $urandom_range(24'hFF_FFFF), $urandom_range(65536));
                6: setup(FUDGE_RST, 32'hFF_FFFF, 32'd655);
                default: setup($urandom, $urandom_range(24'hFF_FFFF), 0);
            endcase
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 75; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 75; end
                default: begin send_idle = 37; recv_stall = 37; end
            endcase
            send_random(125);
        end

        // Long receiver hold-off while the sender keeps pushing.
        setup(FUDGE_RST, MOLIERE_RST, THRESH_RST);
        send_idle = 0;
        recv_stall = 0;
        hold_req = hold_req + 1;
        send_random(300);
        drain();
        send_random(20);

        drain();
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/tscu_pkg.sv
sv/thin_scatter_covariance_update.sv
sim/tb_thin_scatter_covariance_update.sv
